>>> sv/bsrspmv_pkg.sv
// bsrspmv_pkg: shared types and constants for the block-sparse-row
// matrix-vector multiplier. No dependencies.
package bsrspmv_pkg;

	localparam int BLOCK_SIZE_DEF    = 4;
	localparam int VECTOR_LENGTH_DEF = 1024;

	// values carried by one data item
	localparam int NUM_VALS = 4;

	localparam int IDX_W  = 10;
	localparam int VAL_W  = 16;
	localparam int COL_W  = 8;
	localparam int PROD_W = 32;
	// sum of up to four products
	localparam int SUM_W  = PROD_W + 2;
	localparam int ACC_W  = 48;
	// row field wide enough for the largest block
	localparam int ROW_W  = 3;

	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_DATA  = 2'd1;
	localparam logic [1:0] OP_CLOSE = 2'd2;

	typedef struct packed {
		logic [1:0]              opcode;
		logic [IDX_W-1:0]        x_index;
		logic signed [VAL_W-1:0] x_value;
		logic [COL_W-1:0]        block_col;
		logic [1:0]              row_in_block;
		logic signed [VAL_W-1:0] a_val0;
		logic signed [VAL_W-1:0] a_val1;
		logic signed [VAL_W-1:0] a_val2;
		logic signed [VAL_W-1:0] a_val3;
	} in_item_t;

	typedef struct packed {
		logic [IDX_W-1:0]        y_index;
		logic signed [ACC_W-1:0] y_value;
		logic                    last;
	} out_item_t;

	typedef struct packed {
		logic             valid;
		logic             close;
		logic [ROW_W-1:0] row;
	} ctrl_t;

endpackage

>>> sv/bsrspmv_lane.sv
// bsrspmv_lane: one multiply lane with its own copy of the vector store.
// Depends on bsrspmv_pkg.
module bsrspmv_lane #(
	parameter int ADDR_W = 10,
	parameter int DEPTH  = 1024
) (
	input  logic                                      clk,
	input  logic                                      adv,
	input  logic                                      wr_en,
	input  logic [ADDR_W-1:0]                         wr_addr,
	input  logic signed [bsrspmv_pkg::VAL_W-1:0]      wr_data,
	input  logic [ADDR_W-1:0]                         rd_addr,
	input  logic                                      rd_zero,
	input  logic signed [bsrspmv_pkg::VAL_W-1:0]      a_val,
	output logic signed [bsrspmv_pkg::PROD_W-1:0]     prod
);

	logic signed [bsrspmv_pkg::VAL_W-1:0]  mem [DEPTH];
	logic signed [bsrspmv_pkg::VAL_W-1:0]  x_s1;
	logic signed [bsrspmv_pkg::VAL_W-1:0]  a_s1;
	logic                                  zero_s1;
	logic signed [bsrspmv_pkg::PROD_W-1:0] prod_s2;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1    <= mem[rd_addr];
			a_s1    <= a_val;
			zero_s1 <= rd_zero;
			// column beyond the vector reads as zero
			prod_s2 <= zero_s1 ? '0 : bsrspmv_pkg::PROD_W'(a_s1 * x_s1);
		end
	end

	assign prod = prod_s2;

endmodule

>>> sv/bsrspmv_acc.sv
// bsrspmv_acc: merges the lane products, accumulates per row with saturation
// and drains a closed block row. Depends on bsrspmv_pkg.
module bsrspmv_acc #(
	parameter int BLOCK_SIZE = bsrspmv_pkg::BLOCK_SIZE_DEF,
	parameter int NL         = 4
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  bsrspmv_pkg::ctrl_t                    ctrl_s2,
	input  logic signed [bsrspmv_pkg::PROD_W-1:0] prod [NL],
	output logic                                  adv,
	output logic                                  result_valid,
	input  logic                                  result_stall,
	output bsrspmv_pkg::out_item_t                result
);

	localparam int RW = $clog2(BLOCK_SIZE);
	localparam int CW = $clog2(BLOCK_SIZE + 1);
	localparam int AW = bsrspmv_pkg::ACC_W;

	bsrspmv_pkg::ctrl_t                      ctrl_s3;
	logic signed [bsrspmv_pkg::SUM_W-1:0]    sum_next;
	logic signed [bsrspmv_pkg::SUM_W-1:0]    sum_s3;
	logic signed [AW-1:0]                    acc_q  [BLOCK_SIZE];
	logic signed [AW-1:0]                    obuf_q [BLOCK_SIZE];
	logic [CW-1:0]                           cnt_q;
	logic [bsrspmv_pkg::IDX_W-1:0]           idx_q;
	logic [7:0]                              brc_q;
	logic [RW-1:0]                           row_sel;
	logic signed [AW:0]                      acc_wide;
	logic signed [AW-1:0]                    acc_sat;
	logic                                    close_go;
	logic                                    data_go;
	logic                                    take;

	// merge: sum of the lane products
	always_comb begin
		sum_next = '0;
		for (int m = 0; m < NL; m++) begin
			sum_next = sum_next + bsrspmv_pkg::SUM_W'(prod[m]);
		end
	end

	assign adv      = !(ctrl_s3.valid && ctrl_s3.close && (cnt_q != '0));
	assign close_go = adv && ctrl_s3.valid && ctrl_s3.close;
	assign data_go  = adv && ctrl_s3.valid && !ctrl_s3.close;
	assign take     = (cnt_q != '0) && !result_stall;
	assign row_sel  = RW'(ctrl_s3.row);

	always_comb begin
		acc_wide = (AW+1)'(acc_q[row_sel]) + (AW+1)'(sum_s3);
		if (acc_wide[AW] != acc_wide[AW-1]) begin
			acc_sat = acc_wide[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
		end else begin
			acc_sat = acc_wide[AW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s3 <= '0;
		end else if (adv) begin
			ctrl_s3 <= ctrl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s3 <= sum_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < BLOCK_SIZE; r++) begin
				acc_q[r] <= '0;
			end
		end else begin
			for (int r = 0; r < BLOCK_SIZE; r++) begin
				if (close_go) begin
					acc_q[r] <= '0;
				end else if (data_go && (row_sel == RW'(r))) begin
					acc_q[r] <= acc_sat;
				end
			end
		end
	end

	// drain buffer shifts towards entry zero
	always_ff @(posedge clk) begin
		if (close_go) begin
			for (int r = 0; r < BLOCK_SIZE; r++) begin
				obuf_q[r] <= acc_q[r];
			end
			idx_q <= bsrspmv_pkg::IDX_W'(32'(brc_q) * BLOCK_SIZE);
		end else if (take) begin
			for (int r = 0; r < BLOCK_SIZE - 1; r++) begin
				obuf_q[r] <= obuf_q[r+1];
			end
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			brc_q <= '0;
		end else if (close_go) begin
			cnt_q <= CW'(BLOCK_SIZE);
			brc_q <= brc_q + 1'b1;
		end else if (take) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	assign result_valid   = (cnt_q != '0);
	assign result.y_index = idx_q;
	assign result.y_value = obuf_q[0];
	assign result.last    = (cnt_q == CW'(1));

	a_hold_only_on_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |-> result_valid)
		else $error("pipeline held while drain buffer idle");

	a_load_full: assert property (@(posedge clk) disable iff (!arst_n)
		close_go |=> (cnt_q == CW'(BLOCK_SIZE)))
		else $error("drain count wrong after close");

	a_acc_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		close_go |=> (acc_q[0] == '0))
		else $error("accumulator not cleared by close");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && result.last |=> !result_valid)
		else $error("result after last of block row");

endmodule

>>> sv/bsr_sparse_matrix_vector_multiply.sv
// bsr_sparse_matrix_vector_multiply: top level of the block-sparse-row
// matrix times vector unit. Depends on bsrspmv_pkg, bsrspmv_lane, bsrspmv_acc.
//
// usage
//  - item channel (item_valid, item_stall, item): load a vector element,
//    send one row of a stored block, or close the current block row
//  - result channel (result_valid, result_stall, result): BLOCK_SIZE results
//    per close, in row order, last high on the final one
//  - an item enters every cycle unless item_stall is high; a data item passes
//    the s1, s2 and s3 registers to its accumulator, a close passes them to
//    the drain buffer, and the results follow one a cycle unless stalled
//  - the close stage waits while the previous block row is still draining,
//    so a close can hold the input until that drain, receiver stalls included,
//    is over; a stalled result simply stays on the port
//  - each lane keeps its own copy of the vector store (up to 1024 entries,
//    one write and one read port), so all lanes read their columns together
//  - reset clears the accumulators and the block-row counter; the vector
//    store has no reset and must be loaded before it is read
//  - a vector write and a read of the same element by the next item
//    resolve in order since both act on the item's own accept edge
module bsr_sparse_matrix_vector_multiply #(
	parameter int BLOCK_SIZE    = bsrspmv_pkg::BLOCK_SIZE_DEF,
	parameter int VECTOR_LENGTH = bsrspmv_pkg::VECTOR_LENGTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_stall,
	input  bsrspmv_pkg::in_item_t  item,
	output logic                   result_valid,
	input  logic                   result_stall,
	output bsrspmv_pkg::out_item_t result
);

	// lanes: only the carried values can contribute
	localparam int NL    = (BLOCK_SIZE < bsrspmv_pkg::NUM_VALS) ? BLOCK_SIZE
	                                                            : bsrspmv_pkg::NUM_VALS;
	// x_index never exceeds 1023, so the store needs no more entries
	localparam int DEPTH = (VECTOR_LENGTH < 1024) ? VECTOR_LENGTH : 1024;
	localparam int AW    = $clog2(DEPTH);
	// widest column position is block_col * BLOCK_SIZE + NL - 1
	localparam int POS_W = bsrspmv_pkg::COL_W + $clog2(BLOCK_SIZE);

	logic                                  adv;
	logic                                  wr_en;
	bsrspmv_pkg::ctrl_t                    item_ctrl;
	bsrspmv_pkg::ctrl_t                    ctrl_s1;
	bsrspmv_pkg::ctrl_t                    ctrl_s2;
	logic signed [bsrspmv_pkg::VAL_W-1:0]  a_vals [bsrspmv_pkg::NUM_VALS];
	logic signed [bsrspmv_pkg::PROD_W-1:0] prods  [NL];

	assign item_stall = !adv;

	// vector loads beyond the vector length are dropped
	assign wr_en = item_valid && adv && (item.opcode == bsrspmv_pkg::OP_LOAD)
	               && (32'(item.x_index) < 32'(VECTOR_LENGTH));

	assign a_vals[0] = item.a_val0;
	assign a_vals[1] = item.a_val1;
	assign a_vals[2] = item.a_val2;
	assign a_vals[3] = item.a_val3;

	// data items with a row outside the block, loads and the spare opcode
	// leave nothing in the pipeline
	always_comb begin
		item_ctrl.close = (item.opcode == bsrspmv_pkg::OP_CLOSE);
		item_ctrl.row   = bsrspmv_pkg::ROW_W'(item.row_in_block);
		item_ctrl.valid = item_valid
		                  && (((item.opcode == bsrspmv_pkg::OP_DATA)
		                       && (32'(item.row_in_block) < 32'(BLOCK_SIZE)))
		                      || item_ctrl.close);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
			ctrl_s2 <= '0;
		end else if (adv) begin
			ctrl_s1 <= item_ctrl;
			ctrl_s2 <= ctrl_s1;
		end
	end

	for (genvar m = 0; m < NL; m++) begin : g_lane
		logic [POS_W-1:0] pos;
		logic             pos_zero;

		assign pos      = POS_W'(item.block_col) * POS_W'(BLOCK_SIZE) + POS_W'(m);
		assign pos_zero = (32'(pos) >= 32'(VECTOR_LENGTH));

		bsrspmv_lane #(
			.ADDR_W (AW),
			.DEPTH  (DEPTH)
		) u_lane (
			.clk     (clk),
			.adv     (adv),
			.wr_en   (wr_en),
			.wr_addr (AW'(item.x_index)),
			.wr_data (item.x_value),
			.rd_addr (AW'(pos)),
			.rd_zero (pos_zero),
			.a_val   (a_vals[m]),
			.prod    (prods[m])
		);
	end

	bsrspmv_acc #(
		.BLOCK_SIZE (BLOCK_SIZE),
		.NL         (NL)
	) u_acc (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl_s2      (ctrl_s2),
		.prod         (prods),
		.adv          (adv),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

>>> tb/bsrspmv_checker.sv
// bsrspmv_checker: watches both channels of the block-sparse-row multiplier,
// keeps its own copy of the vector store and row sums, and compares results.
// Depends on bsrspmv_pkg.
module bsrspmv_checker #(
	parameter int BLOCK_SIZE    = bsrspmv_pkg::BLOCK_SIZE_DEF,
	parameter int VECTOR_LENGTH = bsrspmv_pkg::VECTOR_LENGTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	input  logic                   item_stall,
	input  bsrspmv_pkg::in_item_t  item,
	input  logic                   result_valid,
	input  logic                   result_stall,
	input  bsrspmv_pkg::out_item_t result,
	output int                     errors,
	output int                     pending,
	output int                     checked
);

	localparam longint ACC_HI    = 64'sh0000_7fff_ffff_ffff;
	localparam longint ACC_LO    = -ACC_HI - 1;
	localparam int     PRINT_CAP = 200;

	logic signed [bsrspmv_pkg::VAL_W-1:0] x_store [VECTOR_LENGTH];
	longint                               row_sum [BLOCK_SIZE];
	logic [7:0]                           block_row;
	bsrspmv_pkg::out_item_t               y_expected [$];

	initial begin
		errors  = 0;
		checked = 0;
		pending = 0;
	end

	task automatic flag_mismatch(input string what);
		errors++;
		if (errors <= PRINT_CAP)
			$display("mismatch at %0t: %s", $time, what);
	endtask

	// update the store and row sums, queue the rows of a closed block row
	task automatic apply_item(input bsrspmv_pkg::in_item_t it);
		logic signed [bsrspmv_pkg::VAL_W-1:0] a [bsrspmv_pkg::NUM_VALS];
		longint                 dot;
		longint                 total;
		int                     pos;
		int                     m;
		bsrspmv_pkg::out_item_t y;
		a[0] = it.a_val0;
		a[1] = it.a_val1;
		a[2] = it.a_val2;
		a[3] = it.a_val3;
		case (it.opcode)
			bsrspmv_pkg::OP_LOAD: begin
				if (int'(it.x_index) < VECTOR_LENGTH)
					x_store[it.x_index] = it.x_value;
			end
			bsrspmv_pkg::OP_DATA: begin
				if (int'(it.row_in_block) < BLOCK_SIZE) begin
					dot = 0;
					for (m = 0; m < BLOCK_SIZE && m < bsrspmv_pkg::NUM_VALS; m++) begin
						pos = int'(it.block_col) * BLOCK_SIZE + m;
						if (pos < VECTOR_LENGTH)
							dot += longint'(a[m]) * longint'(x_store[pos]);
					end
					total = row_sum[it.row_in_block] + dot;
					if (total > ACC_HI)
						total = ACC_HI;
					else if (total < ACC_LO)
						total = ACC_LO;
					row_sum[it.row_in_block] = total;
				end
			end
			bsrspmv_pkg::OP_CLOSE: begin
				for (m = 0; m < BLOCK_SIZE; m++) begin
					y.y_index = bsrspmv_pkg::IDX_W'(int'(block_row) * BLOCK_SIZE + m);
					y.y_value = bsrspmv_pkg::ACC_W'(row_sum[m]);
					y.last    = (m == BLOCK_SIZE - 1);
					y_expected.push_back(y);
					row_sum[m] = 0;
				end
				block_row = block_row + 8'd1;
			end
			default: ;
		endcase
	endtask

	task automatic check_result(input bsrspmv_pkg::out_item_t got);
		bsrspmv_pkg::out_item_t want;
		if (y_expected.size() == 0) begin
			flag_mismatch($sformatf("result at y_index %0d with nothing expected",
				got.y_index));
			return;
		end
		want = y_expected.pop_front();
		checked++;
		if (got.y_index !== want.y_index)
			flag_mismatch($sformatf("y_index %0d, expected %0d", got.y_index, want.y_index));
		if (got.y_value !== want.y_value)
			flag_mismatch($sformatf("y_index %0d: y_value %0d, expected %0d",
				want.y_index, got.y_value, want.y_value));
		if (got.last !== want.last)
			flag_mismatch($sformatf("y_index %0d: last %b, expected %b",
				want.y_index, got.last, want.last));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (row_sum[r])
				row_sum[r] = 0;
			block_row = '0;
			y_expected.delete();
			pending = 0;
		end else begin
			if (result_valid && !result_stall)
				check_result(result);
			if (item_valid && !item_stall)
				apply_item(item);
			pending = y_expected.size();
		end
	end

endmodule

>>> tb/testbench.sv
// testbench: drives vector loads, block rows and closes into the block-sparse-row
// multiplier and gives the verdict. Depends on bsrspmv_pkg,
// bsr_sparse_matrix_vector_multiply and bsrspmv_checker.
module testbench;

	// opcode the block must ignore
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam int BS           = bsrspmv_pkg::BLOCK_SIZE_DEF;
	localparam int RANDOM_ITEMS = 140;
	// closing run of closes with the odd data item in between
	localparam int CLOSE_RUN    = 20;
	localparam int RX_HOLD      = 120;
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT  = 300000;

	localparam logic signed [bsrspmv_pkg::VAL_W-1:0] Q15_MAX = 16'sh7fff;
	localparam logic signed [bsrspmv_pkg::VAL_W-1:0] Q15_MIN = 16'sh8000;

	logic                   clk          = 1'b0;
	logic                   arst_n       = 1'b0;
	logic                   item_valid   = 1'b0;
	logic                   result_stall = 1'b0;
	bsrspmv_pkg::in_item_t  item         = '0;
	logic                   item_stall;
	logic                   result_valid;
	bsrspmv_pkg::out_item_t result;

	int errors;
	int pending;
	int checked;

	// sender-side bookkeeping: which vector entries and columns are safe to read
	bit x_written [bsrspmv_pkg::VECTOR_LENGTH_DEF];
	bit col_ready [256];
	int ready_cols [$];

	int n_load   = 0;
	int n_data   = 0;
	int n_close  = 0;
	int n_unused = 0;
	int cycles   = 0;
	int burst_left = 0;

	// long receiver hold-off, asked for once by the sender
	bit hold_req  = 1'b0;
	bit hold_done = 1'b0;

	bsr_sparse_matrix_vector_multiply uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	bsrspmv_checker spmv_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.errors       (errors),
		.pending      (pending),
		.checked      (checked)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// hard stop if the run hangs
	initial begin : watchdog
		while (cycles <= CYCLE_LIMIT)
			@(posedge clk) cycles++;
		$display("simulation failed");
		$finish;
	end

	// mostly random values, with the extremes and zero turning up often
	function automatic logic signed [bsrspmv_pkg::VAL_W-1:0] pick_q15();
		case ($urandom_range(0, 9))
			0: return Q15_MAX;
			1: return Q15_MIN;
			2: return '0;
			default: return bsrspmv_pkg::VAL_W'($urandom);
		endcase
	endfunction

	// sender gaps: mostly none, some short, a few long, and bursts with none at all
	function automatic int pick_gap();
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		case ($urandom_range(0, 19))
			0: begin
				burst_left = $urandom_range(15, 40);
				return 0;
			end
			1: return $urandom_range(6, 20);
			2, 3, 4, 5, 6: return $urandom_range(1, 3);
			default: return 0;
		endcase
	endfunction

	// every field random, so fields an opcode does not use still toggle
	function automatic bsrspmv_pkg::in_item_t any_item(input logic [1:0] op);
		bsrspmv_pkg::in_item_t it;
		it.opcode       = op;
		it.x_index      = bsrspmv_pkg::IDX_W'($urandom);
		it.x_value      = pick_q15();
		it.block_col    = bsrspmv_pkg::COL_W'($urandom);
		it.row_in_block = 2'($urandom);
		it.a_val0       = pick_q15();
		it.a_val1       = pick_q15();
		it.a_val2       = pick_q15();
		it.a_val3       = pick_q15();
		return it;
	endfunction

	// a block column whose four vector entries have all been loaded
	function automatic logic [bsrspmv_pkg::COL_W-1:0] pick_col();
		return bsrspmv_pkg::COL_W'(ready_cols[$urandom_range(0, ready_cols.size() - 1)]);
	endfunction

	// offer one item from a falling edge, hold it until taken, return at the next falling edge
	task automatic send_item(input bsrspmv_pkg::in_item_t it);
		int gap;
		int col;
		gap = pick_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		item       <= it;
		do
			@(posedge clk);
		while (item_stall);
		@(negedge clk);
		case (it.opcode)
			bsrspmv_pkg::OP_LOAD: begin
				n_load++;
				x_written[it.x_index] = 1'b1;
				col = int'(it.x_index) / BS;
				if (!col_ready[col] && x_written[col*BS] && x_written[col*BS+1]
						&& x_written[col*BS+2] && x_written[col*BS+3]) begin
					col_ready[col] = 1'b1;
					ready_cols.push_back(col);
				end
			end
			bsrspmv_pkg::OP_DATA:  n_data++;
			bsrspmv_pkg::OP_CLOSE: n_close++;
			default:  n_unused++;
		endcase
	endtask

	task automatic load_elem(input logic [bsrspmv_pkg::IDX_W-1:0] idx,
			input logic signed [bsrspmv_pkg::VAL_W-1:0] v);
		bsrspmv_pkg::in_item_t it;
		it         = any_item(bsrspmv_pkg::OP_LOAD);
		it.x_index = idx;
		it.x_value = v;
		send_item(it);
	endtask

	task automatic send_data(input logic [bsrspmv_pkg::COL_W-1:0] col, input logic [1:0] row,
			input logic signed [bsrspmv_pkg::VAL_W-1:0] a0,
			input logic signed [bsrspmv_pkg::VAL_W-1:0] a1,
			input logic signed [bsrspmv_pkg::VAL_W-1:0] a2,
			input logic signed [bsrspmv_pkg::VAL_W-1:0] a3);
		bsrspmv_pkg::in_item_t it;
		it              = any_item(bsrspmv_pkg::OP_DATA);
		it.block_col    = col;
		it.row_in_block = row;
		it.a_val0       = a0;
		it.a_val1       = a1;
		it.a_val2       = a2;
		it.a_val3       = a3;
		send_item(it);
	endtask

	// drop valid and wait until every queued result has come out
	task automatic wait_drained();
		item_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
	endtask

	// receiver: random stalls with quiet stretches, plus one long hold-off on request
	initial begin : receiver
		int stall_left;
		int free_left;
		stall_left = 0;
		free_left  = 0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				hold_done  = 1'b1;
				stall_left = RX_HOLD;
			end else if (stall_left == 0 && free_left == 0) begin
				case ($urandom_range(0, 9))
					0: stall_left = $urandom_range(8, 30);
					1, 2, 3: stall_left = $urandom_range(1, 3);
					4: free_left = $urandom_range(20, 60);
					default: free_left = $urandom_range(1, 4);
				endcase
			end
			if (stall_left > 0) begin
				result_stall <= 1'b1;
				stall_left--;
			end else begin
				result_stall <= 1'b0;
				free_left--;
			end
		end
	end

	initial begin : stimulus
		int col;
		int i;
		int k;
		int goal;
		bit paused;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: extremes at both ends of the vector
		load_elem(10'd0, Q15_MAX);
		load_elem(10'd1, Q15_MIN);
		load_elem(10'd2, 16'sd1);
		load_elem(10'd3, -16'sd1);
		load_elem(10'd1020, Q15_MIN);
		load_elem(10'd1021, Q15_MIN);
		load_elem(10'd1022, Q15_MAX);
		load_elem(10'd1023, '0);

		// every row, largest and most negative products, two rows hit twice
		send_data(8'd0, 2'd0, Q15_MAX, Q15_MAX, Q15_MAX, Q15_MAX);
		send_data(8'd0, 2'd1, Q15_MIN, Q15_MIN, Q15_MIN, Q15_MIN);
		send_data(8'd255, 2'd2, Q15_MIN, Q15_MIN, Q15_MIN, Q15_MIN);
		send_data(8'd255, 2'd3, Q15_MAX, Q15_MIN, Q15_MAX, Q15_MIN);
		send_data(8'd0, 2'd3, '0, '0, '0, '0);
		send_data(8'd255, 2'd2, Q15_MAX, Q15_MAX, Q15_MAX, Q15_MAX);
		send_item(any_item(bsrspmv_pkg::OP_CLOSE));

		// empty block row gives zeros; unused opcode gives nothing
		send_item(any_item(bsrspmv_pkg::OP_CLOSE));
		send_item(any_item(OP_UNUSED));
		send_data(8'd0, 2'd0, 16'sd1, -16'sd1, Q15_MAX, Q15_MIN);
		send_item(any_item(bsrspmv_pkg::OP_CLOSE));
		wait_drained();

		// random: mostly well-formed block rows, some stray loads, closes and noise
		hold_req = 1'b1;
		paused   = 1'b0;
		goal     = n_load + n_data + n_close + RANDOM_ITEMS;
		while (n_load + n_data + n_close < goal) begin
			case ($urandom_range(0, 19))
				0, 1: load_elem(bsrspmv_pkg::IDX_W'($urandom), pick_q15());
				2: send_item(any_item(OP_UNUSED));
				3: send_item(any_item(bsrspmv_pkg::OP_CLOSE));
				default: begin
					if ($urandom_range(0, 1)) begin
						col = $urandom_range(0, 255);
						for (i = 0; i < BS; i++)
							load_elem(bsrspmv_pkg::IDX_W'(col * BS + i), pick_q15());
					end
					k = $urandom_range(0, 6);
					repeat (k)
						send_data(pick_col(), 2'($urandom), pick_q15(), pick_q15(),
							pick_q15(), pick_q15());
					send_item(any_item(bsrspmv_pkg::OP_CLOSE));
				end
			endcase
			// one full drain half way through
			if (!paused && n_load + n_data + n_close >= goal - RANDOM_ITEMS / 2) begin
				paused = 1'b1;
				wait_drained();
			end
		end
		wait_drained();

		// closes one after another so each waits on the previous drain
		for (i = 0; i < CLOSE_RUN; i++) begin
			if (i % 5 == 0)
				send_data(pick_col(), 2'($urandom), pick_q15(), pick_q15(),
					pick_q15(), pick_q15());
			send_item(any_item(bsrspmv_pkg::OP_CLOSE));
		end

		item_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("covered %0d loads, %0d block-row data items, %0d closes, %0d ignored items",
			n_load, n_data, n_close, n_unused);
		$display("%0d results compared, %0d mismatches, under random and long receiver stalls",
			checked, errors);
		if (errors == 0 && pending == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
